[sv/lss_pkg.sv]
`timescale 1ns / 1ps

package lss_pkg;

    // Table geometry and duration range.
    localparam int MAX_STEPS     = 16;
    localparam int DURATION_BITS = 24;

    localparam int POS_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int DUR_W = DURATION_BITS;

    // Lamp bits.
    localparam logic [2:0] LAMP_GREEN  = 3'b001;
    localparam logic [2:0] LAMP_ORANGE = 3'b010;
    localparam logic [2:0] LAMP_RED    = 3'b100;
    localparam logic [2:0] LAMP_ALL    = LAMP_GREEN | LAMP_ORANGE | LAMP_RED;

    // Opcodes of an input beat.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  step_slot;
        logic [2:0]  step_mask;
        logic [23:0] step_duration;
        logic [4:0]  step_total;
        logic        loop_flag;
    } t_in_item;

    typedef struct packed {
        logic [2:0] lamp_mask;
        logic       mode_active;
        logic [3:0] current_step;
    } t_out_item;

    // Write request into the step table.
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] slot;
        logic [2:0]       mask;
        logic [DUR_W-1:0] dur;
    } t_tbl_wr;

    // Clear request for the entries below a count.
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] count;
    } t_tbl_clr;

endpackage

[sv/lss_table.sv]
`timescale 1ns / 1ps

module lss_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lss_pkg::t_tbl_wr         i_wr,
    input  lss_pkg::t_tbl_clr        i_clr,
    input  logic [lss_pkg::POS_W-1:0] i_dur_addr,
    input  logic [lss_pkg::POS_W-1:0] i_mask_addr,
    output logic [lss_pkg::DUR_W-1:0] o_dur,
    output logic [2:0]               o_mask
);
    import lss_pkg::*;

    logic [DUR_W-1:0] r_dur   [MAX_STEPS];
    logic [2:0]       r_mask  [MAX_STEPS];
    logic [MAX_STEPS-1:0] r_valid;
    logic [MAX_STEPS-1:0] n_valid;

    // Entry contents carry no reset; the valid bits stand for it.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_dur[i_wr.slot]  <= i_wr.dur;
            r_mask[i_wr.slot] <= i_wr.mask;
        end
    end

    // A one-shot end drops every entry below the step count at once.
    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < MAX_STEPS; i++) begin
            if (i_clr.en && (CNT_W'(i) < i_clr.count)) begin
                n_valid[i] = 1'b0;
            end
        end
        if (i_wr.en) begin
            n_valid[i_wr.slot] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // An entry that is not valid reads as zero.
    assign o_dur  = r_valid[i_dur_addr]  ? r_dur[i_dur_addr]   : '0;
    assign o_mask = r_valid[i_mask_addr] ? r_mask[i_mask_addr] : 3'b000;

endmodule

[sv/lamp_step_sequencer.sv]
`timescale 1ns / 1ps

// Three-lamp step sequencer.
// Input channel (i_valid / o_ready, payload i_item) carries one command per beat:
// a one-millisecond tick, a write of one step (mask and duration) into the
// 16-entry step table, or a start of a mode (step count and loop flag).
// Output channel (o_valid / i_ready, payload o_item) returns exactly one beat per
// input beat: the lamps driven, whether a mode runs, and the current step index.
// An accepted beat is held in the input register and passes through one stage of
// logic into the result register, which drives the port.
// Throughput is one beat per cycle while the receiver keeps up, set by the single
// state update per item. When the receiver stalls, the result register holds and
// the input register keeps one more beat; o_ready then drops until the result is
// taken. Reset (synchronous, active low) empties both registers, clears the table,
// stops any mode and turns all three lamps on.
module lamp_step_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lss_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output lss_pkg::t_out_item o_item
);
    import lss_pkg::*;

    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       advance;

    logic [POS_W-1:0] r_pos,     n_pos;
    logic [DUR_W-1:0] r_elapsed, n_elapsed;
    logic [CNT_W-1:0] r_steps,   n_steps;
    logic             r_repeat,  n_repeat;
    logic [2:0]       r_lamp,    n_lamp;

    t_tbl_wr          tbl_wr;
    t_tbl_clr         tbl_clr;
    logic [POS_W-1:0] mask_addr;
    logic [DUR_W-1:0] cur_dur;
    logic [2:0]       rd_mask;

    logic [DUR_W-1:0] elapsed_inc;
    logic [CNT_W-1:0] pos_inc;
    logic             step_done;
    logic             wrap;
    logic             is_tick;
    logic             is_start;

    // Handshake: the stage moves when the result register is free or drained.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
        if (advance) begin
            r_out.lamp_mask    <= n_lamp;
            r_out.mode_active  <= (n_steps != '0);
            r_out.current_step <= 4'(n_pos);
        end
    end

    // Step table.
    lss_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (tbl_wr),
        .i_clr       (tbl_clr),
        .i_dur_addr  (r_pos),
        .i_mask_addr (mask_addr),
        .o_dur       (cur_dur),
        .o_mask      (rd_mask)
    );

    // Tick arithmetic on the current step.
    assign is_tick     = advance && (r_in.opcode == OP_TICK) && (r_steps != '0);
    assign is_start    = advance && (r_in.opcode == OP_START);
    assign elapsed_inc = (r_elapsed == DUR_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign step_done   = !(elapsed_inc < cur_dur);
    assign pos_inc     = CNT_W'(r_pos) + 1'b1;
    assign wrap        = (pos_inc >= r_steps);
    assign mask_addr   = (is_start || wrap) ? '0 : pos_inc[POS_W-1:0];

    // Table write and one-shot clear requests.
    always_comb begin
        tbl_wr.en   = advance && (r_in.opcode == OP_WRITE)
                      && (32'(r_in.step_slot) < 32'(MAX_STEPS));
        tbl_wr.slot = POS_W'(r_in.step_slot);
        tbl_wr.mask = r_in.step_mask;
        tbl_wr.dur  = DUR_W'(r_in.step_duration);

        tbl_clr.en    = is_tick && step_done && wrap && !r_repeat;
        tbl_clr.count = r_steps;
    end

    // Next state of the sequencer.
    always_comb begin
        n_pos     = r_pos;
        n_elapsed = r_elapsed;
        n_steps   = r_steps;
        n_repeat  = r_repeat;
        n_lamp    = r_lamp;
        case (r_in.opcode)
            OP_TICK: begin
                if (r_steps != '0) begin
                    n_elapsed = elapsed_inc;
                    if (step_done) begin
                        if (wrap && !r_repeat) begin
                            n_steps   = '0;
                            n_repeat  = 1'b0;
                            n_pos     = '0;
                            n_elapsed = '0;
                        end else begin
                            n_pos     = mask_addr;
                            n_elapsed = '0;
                            n_lamp    = rd_mask;
                        end
                    end
                end
            end
            OP_START: begin
                n_steps   = (32'(r_in.step_total) > 32'(MAX_STEPS))
                            ? CNT_W'(MAX_STEPS) : CNT_W'(r_in.step_total);
                n_repeat  = r_in.loop_flag;
                n_pos     = '0;
                n_elapsed = '0;
                n_lamp    = rd_mask;
            end
            default: begin
                // Table writes and the unused opcode leave the sequencer alone.
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_elapsed <= '0;
            r_steps   <= '0;
            r_repeat  <= 1'b0;
            r_lamp    <= LAMP_ALL;
        end else if (advance) begin
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
            r_steps   <= n_steps;
            r_repeat  <= n_repeat;
            r_lamp    <= n_lamp;
        end
    end

`ifndef SYNTHESIS
    // The step count never exceeds the table size.
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_steps) <= 32'(MAX_STEPS))
        else $error("step count above table size");

    // A running mode points inside its own steps.
    a_pos_in_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steps != '0) |-> (CNT_W'(r_pos) < r_steps))
        else $error("step position outside the mode");

    // An idle sequencer rests at step zero with no elapsed time.
    a_idle_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steps == '0) |-> ((r_pos == '0) && (r_elapsed == '0)))
        else $error("idle sequencer holds a position or elapsed time");

    // A waiting result always matches the state it was taken from.
    a_out_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.mode_active == (r_steps != '0))
                         && (r_out.lamp_mask == r_lamp)
                         && (r_out.current_step == 4'(r_pos))))
        else $error("result out of step with sequencer state");

    // Every beat that moves through the stage produces a result.
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced beat lost its result");
`endif

endmodule
